// File: design/apse_pkg.sv
// ----------------------------------------------------------------------------
// apse_pkg
// Shared widths, register codes and reset values of the swap evaluator.
// ----------------------------------------------------------------------------
package apse_pkg;

    // Input and result field widths
    localparam int COORD_W  = 10;
    localparam int WEIGHT_W = 31;
    localparam int RAND_W   = 16;
    localparam int DELTA_W  = 63;

    // Configuration register widths
    localparam int TEMP_W     = 32;
    localparam int INV_W      = 25;
    localparam int INV_FRAC_W = 16;

    // Datapath widths: weight difference, coordinate difference, weighted factor, corrected factor, delta
    localparam int DK_W = WEIGHT_W + 1;
    localparam int DC_W = COORD_W + 1;
    localparam int M_W  = DK_W + DC_W + 1;
    localparam int E_W  = M_W + 1;
    localparam int D_W  = E_W + DC_W;

    // Exp table entry width: values run up to 65536
    localparam int ROM_W = 17;

    // Stream and APB widths
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 88;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ACCEPT_MODE = 2'd0;
    localparam logic [1:0] REG_TEMPERATURE = 2'd1;
    localparam logic [1:0] REG_INV_TEMP    = 2'd2;

    // Register reset values
    localparam logic              RST_ACCEPT_MODE = 1'b0;
    localparam logic [TEMP_W-1:0] RST_TEMPERATURE = 32'd65535;
    localparam logic [INV_W-1:0]  RST_INV_TEMP    = 25'd256;

    // Acceptance modes
    localparam logic MODE_METROPOLIS = 1'b0;
    localparam logic MODE_THRESHOLD  = 1'b1;

endpackage

// File: design/apse_ram.sv
// ----------------------------------------------------------------------------
// apse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apse_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/apse_exp_rom.sv
// ----------------------------------------------------------------------------
// apse_exp_rom
// Exp acceptance table: fills a RAM after reset with round(65536 *
// exp(-(i + 0.5) / steps)), one entry per pass of the fill states, using
// a shared 32x31 multiplier for the Q62 recurrence v = v * exp(-1/steps).
// ----------------------------------------------------------------------------
module apse_exp_rom #(
    parameter int LUT_ENTRIES        = 4096,
    parameter int LUT_STEPS_PER_UNIT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_re,
    input  logic [$clog2(LUT_ENTRIES)-1:0] i_raddr,
    output logic [apse_pkg::ROM_W-1:0]     o_rdata,
    output logic                           o_ready
);

    localparam int AW    = $clog2(LUT_ENTRIES);
    localparam int ACC_W = 125;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Series for exp(-1/(2*steps)) in Q62
    localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
    localparam logic [63:0] DIV = 64'(2 * LUT_STEPS_PER_UNIT);
    localparam logic [63:0] T01 = ONE_Q62 / (DIV * 64'd1);
    localparam logic [63:0] T02 = T01 / (DIV * 64'd2);
    localparam logic [63:0] T03 = T02 / (DIV * 64'd3);
    localparam logic [63:0] T04 = T03 / (DIV * 64'd4);
    localparam logic [63:0] T05 = T04 / (DIV * 64'd5);
    localparam logic [63:0] T06 = T05 / (DIV * 64'd6);
    localparam logic [63:0] T07 = T06 / (DIV * 64'd7);
    localparam logic [63:0] T08 = T07 / (DIV * 64'd8);
    localparam logic [63:0] T09 = T08 / (DIV * 64'd9);
    localparam logic [63:0] T10 = T09 / (DIV * 64'd10);
    localparam logic [63:0] T11 = T10 / (DIV * 64'd11);
    localparam logic [63:0] T12 = T11 / (DIV * 64'd12);
    localparam logic [63:0] T13 = T12 / (DIV * 64'd13);
    localparam logic [63:0] T14 = T13 / (DIV * 64'd14);
    localparam logic [63:0] T15 = T14 / (DIV * 64'd15);
    localparam logic [63:0] T16 = T15 / (DIV * 64'd16);
    localparam logic [63:0] T17 = T16 / (DIV * 64'd17);
    localparam logic [63:0] T18 = T17 / (DIV * 64'd18);
    localparam logic [63:0] T19 = T18 / (DIV * 64'd19);
    localparam logic [63:0] T20 = T19 / (DIV * 64'd20);
    localparam logic [63:0] T21 = T20 / (DIV * 64'd21);
    localparam logic [63:0] T22 = T21 / (DIV * 64'd22);
    localparam logic [63:0] T23 = T22 / (DIV * 64'd23);
    localparam logic [63:0] T24 = T23 / (DIV * 64'd24);
    localparam logic [63:0] HALF = ONE_Q62 - T01 + T02 - T03 + T04 - T05 + T06 - T07 + T08
                                 - T09 + T10 - T11 + T12 - T13 + T14 - T15 + T16 - T17
                                 + T18 - T19 + T20 - T21 + T22 - T23 + T24;
    localparam logic [63:0] STEP = mul_q62(HALF, HALF);

    typedef enum logic [2:0] {
        FP_LL,
        FP_LH,
        FP_HL,
        FP_HH,
        FP_ADD,
        FP_NEXT,
        FP_DONE
    } t_fill_state;

    t_fill_state      r_state;
    logic [62:0]      r_v;
    logic [AW-1:0]    r_idx;
    logic [ACC_W-1:0] r_prod;
    logic [ACC_W-1:0] r_acc;

    logic [31:0]              w_op_a;
    logic [30:0]              w_op_b;
    logic [62:0]              w_prod;
    logic [ACC_W-1:0]         w_prod_sh;
    logic [62:0]              w_rnd_sum;
    logic [apse_pkg::ROM_W-1:0] w_entry;

    // Partial products of v * STEP, split at bit 31
    always_comb begin
        w_op_a = ((r_state == FP_LL) || (r_state == FP_LH)) ? {1'b0, r_v[30:0]} : r_v[62:31];
        w_op_b = ((r_state == FP_LL) || (r_state == FP_HL)) ? STEP[30:0] : STEP[61:31];
        w_prod = 63'(w_op_a * w_op_b);
        case (r_state)
            FP_LL:        w_prod_sh = ACC_W'(w_prod);
            FP_LH, FP_HL: w_prod_sh = ACC_W'(w_prod) << 31;
            FP_HH:        w_prod_sh = ACC_W'(w_prod) << 62;
            default:      w_prod_sh = '0;
        endcase
    end

    // Round half up to the 16-bit fraction
    assign w_rnd_sum = r_v + (63'd1 << 45);
    assign w_entry   = w_rnd_sum[62:46];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FP_LL;
            r_v     <= HALF[62:0];
            r_idx   <= '0;
            r_prod  <= '0;
            r_acc   <= '0;
        end else begin
            case (r_state)
                FP_LL: begin
                    if (r_idx == AW'(LUT_ENTRIES - 1)) begin
                        r_state <= FP_DONE;
                    end else begin
                        r_acc   <= '0;
                        r_prod  <= w_prod_sh;
                        r_state <= FP_LH;
                    end
                end
                FP_LH: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= w_prod_sh;
                    r_state <= FP_HL;
                end
                FP_HL: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= w_prod_sh;
                    r_state <= FP_HH;
                end
                FP_HH: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= w_prod_sh;
                    r_state <= FP_ADD;
                end
                FP_ADD: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= FP_NEXT;
                end
                FP_NEXT: begin
                    r_v     <= r_acc[124:62];
                    r_idx   <= r_idx + 1'b1;
                    r_state <= FP_LL;
                end
                FP_DONE: begin
                    r_state <= FP_DONE;
                end
                default: begin
                    r_state <= FP_LL;
                end
            endcase
        end
    end

    assign o_ready = (r_state == FP_DONE);

    apse_ram #(
        .WIDTH (apse_pkg::ROM_W),
        .DEPTH (LUT_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == FP_LL),
        .i_waddr (r_idx),
        .i_wdata (w_entry),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );

endmodule

// File: design/annealing_pair_swap_evaluator_unit.sv
// ----------------------------------------------------------------------------
// annealing_pair_swap_evaluator_unit
// Throughput: one pair word per clock through the seven-stage pipeline while
// m_axis_tready keeps the output moving and the exp table is ready.
// Reset: configuration registers return to defaults and stage valids clear;
// the exp table then fills, holding s_axis_tready low.
// Evaluates one slot-pair swap move: quadratic wirelength change,
// Metropolis or threshold acceptance, and the LFSR step of the random word.
// ----------------------------------------------------------------------------
module annealing_pair_swap_evaluator_unit #(
    parameter int LUT_ENTRIES        = 4096,
    parameter int LUT_STEPS_PER_UNIT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Pair words.
    // s_axis_tdata, low bit up: coord_a[9:0], coord_b[19:10], weight_a[50:20],
    // wsum_a[81:51], weight_b[112:82], wsum_b[143:113], random_word[159:144]
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [apse_pkg::S_TDATA_W-1:0]    s_axis_tdata,

    // Result words.
    // m_axis_tdata, low bit up: accept[0], cost_delta[63:1], uphill[64],
    // next_random[80:65], zero fill[87:81]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [apse_pkg::M_TDATA_W-1:0]    m_axis_tdata,

    // Configuration: accept_mode @0x0, temperature @0x4, inv_temp_scaled @0x8
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [apse_pkg::APB_AW-1:0]       paddr,
    input  logic [apse_pkg::APB_DW-1:0]       pwdata,
    output logic [apse_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int AW        = $clog2(LUT_ENTRIES);
    // A product at or above LUT_ENTRIES << 16 always lands beyond the table,
    // so only the low IDX_LIM_W bits of the delta reach the multiplier.
    localparam int IDX_LIM_W = AW + apse_pkg::INV_FRAC_W;
    localparam int PROD_W    = IDX_LIM_W + apse_pkg::INV_W;
    localparam int IDX_W     = PROD_W - apse_pkg::INV_FRAC_W;
    localparam int NSTG      = 7;

    localparam int CW = apse_pkg::COORD_W;
    localparam int WW = apse_pkg::WEIGHT_W;
    localparam int RW = apse_pkg::RAND_W;
    localparam int DW = apse_pkg::D_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                          r_accept_mode;
    logic [apse_pkg::TEMP_W-1:0]   r_temperature;
    logic [apse_pkg::INV_W-1:0]    r_inv_temp;
    logic                          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_mode <= apse_pkg::RST_ACCEPT_MODE;
            r_temperature <= apse_pkg::RST_TEMPERATURE;
            r_inv_temp    <= apse_pkg::RST_INV_TEMP;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                apse_pkg::REG_ACCEPT_MODE: r_accept_mode <= pwdata[0];
                apse_pkg::REG_TEMPERATURE: r_temperature <= pwdata;
                apse_pkg::REG_INV_TEMP:    r_inv_temp    <= pwdata[apse_pkg::INV_W-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            apse_pkg::REG_ACCEPT_MODE: prdata = {31'd0, r_accept_mode};
            apse_pkg::REG_TEMPERATURE: prdata = r_temperature;
            apse_pkg::REG_INV_TEMP:    prdata = {7'd0, r_inv_temp};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its word moves on,
    // so bubbles close up while the output word waits.
    // ------------------------------------------------------------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;
    logic          w_rom_ready;
    logic          w_in_fire;

    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1] && w_rom_ready;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= w_in_fire;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [CW-1:0] w_coord_a, w_coord_b;
    logic [WW-1:0] w_weight_a, w_wsum_a, w_weight_b, w_wsum_b;
    logic [RW-1:0] w_random_word;

    assign w_coord_a     = s_axis_tdata[9:0];
    assign w_coord_b     = s_axis_tdata[19:10];
    assign w_weight_a    = s_axis_tdata[50:20];
    assign w_wsum_a      = s_axis_tdata[81:51];
    assign w_weight_b    = s_axis_tdata[112:82];
    assign w_wsum_b      = s_axis_tdata[143:113];
    assign w_random_word = s_axis_tdata[159:144];

    // delta = (cb - ca) * ((ka - kb) * (cb + ca) - 2 * (sa - sb))

    // Stage 1: differences and coordinate sum
    logic signed [apse_pkg::DK_W-1:0] r_s1_dk, r_s1_ds;
    logic signed [apse_pkg::DC_W-1:0] r_s1_dc;
    logic        [CW:0]               r_s1_sc;
    logic        [RW-1:0]             r_s1_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_dk  <= $signed({1'b0, w_weight_a}) - $signed({1'b0, w_weight_b});
            r_s1_ds  <= $signed({1'b0, w_wsum_a}) - $signed({1'b0, w_wsum_b});
            r_s1_dc  <= $signed({1'b0, w_coord_b}) - $signed({1'b0, w_coord_a});
            r_s1_sc  <= {1'b0, w_coord_a} + {1'b0, w_coord_b};
            r_s1_rnd <= w_random_word;
        end
    end

    // Stage 2: weight difference times coordinate sum
    logic signed [apse_pkg::M_W-1:0]  r_s2_m;
    logic signed [apse_pkg::DK_W-1:0] r_s2_ds;
    logic signed [apse_pkg::DC_W-1:0] r_s2_dc;
    logic        [RW-1:0]             r_s2_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_m   <= r_s1_dk * $signed({1'b0, r_s1_sc});
            r_s2_ds  <= r_s1_ds;
            r_s2_dc  <= r_s1_dc;
            r_s2_rnd <= r_s1_rnd;
        end
    end

    // Stage 3: subtract twice the weighted-sum difference
    logic signed [apse_pkg::E_W-1:0]  r_s3_e;
    logic signed [apse_pkg::DC_W-1:0] r_s3_dc;
    logic        [RW-1:0]             r_s3_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_e   <= r_s2_m - $signed({r_s2_ds, 1'b0});
            r_s3_dc  <= r_s2_dc;
            r_s3_rnd <= r_s2_rnd;
        end
    end

    // Stage 4: times coordinate difference gives the cost delta
    logic signed [DW-1:0] r_s4_d;
    logic        [RW-1:0] r_s4_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_d   <= r_s3_e * r_s3_dc;
            r_s4_rnd <= r_s3_rnd;
        end
    end

    // Stage 5: delta times inverse temperature, flag deltas too large
    logic signed [DW-1:0]     r_s5_d;
    logic        [PROD_W-1:0] r_s5_prod;
    logic                     r_s5_over;
    logic        [RW-1:0]     r_s5_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_d    <= r_s4_d;
            r_s5_prod <= PROD_W'(r_s4_d[IDX_LIM_W-1:0] * r_inv_temp);
            r_s5_over <= !r_s4_d[DW-1] && (|r_s4_d[DW-2:IDX_LIM_W]) && (r_inv_temp != '0);
            r_s5_rnd  <= r_s4_rnd;
        end
    end

    // Table index; the table read registers alongside stage 6
    logic [IDX_W-1:0]             w_idx;
    logic                         w_in_range;
    logic [apse_pkg::ROM_W-1:0]   w_rom_data;

    assign w_idx      = r_s5_prod[PROD_W-1:apse_pkg::INV_FRAC_W];
    assign w_in_range = !r_s5_over && (w_idx < IDX_W'(LUT_ENTRIES));

    apse_exp_rom #(
        .LUT_ENTRIES        (LUT_ENTRIES),
        .LUT_STEPS_PER_UNIT (LUT_STEPS_PER_UNIT)
    ) u_exp_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_en[6]),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rom_data),
        .o_ready (w_rom_ready)
    );

    // Stage 6: hold delta and range flag next to the table word
    logic signed [DW-1:0] r_s6_d;
    logic                 r_s6_in_range;
    logic        [RW-1:0] r_s6_rnd;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_d        <= r_s5_d;
            r_s6_in_range <= w_in_range;
            r_s6_rnd      <= r_s5_rnd;
        end
    end

    // Stage 7: decide and register the result word
    logic                           w_accept;
    logic                           r_out_accept;
    logic [apse_pkg::DELTA_W-1:0]   r_out_delta;
    logic                           r_out_uphill;
    logic [RW-1:0]                  r_out_next_rnd;

    always_comb begin
        if (r_s6_d[DW-1]) begin
            w_accept = 1'b1;  // downhill always swaps
        end else if (r_accept_mode == apse_pkg::MODE_THRESHOLD) begin
            w_accept = {16'd0, r_s6_rnd} < r_temperature;
        end else begin
            w_accept = r_s6_in_range && ({1'b0, r_s6_rnd} < w_rom_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG]) begin
            r_out_accept   <= w_accept;
            r_out_delta    <= {{(apse_pkg::DELTA_W - DW){r_s6_d[DW-1]}}, r_s6_d};
            r_out_uphill   <= !r_s6_d[DW-1] && (r_s6_d != '0);
            r_out_next_rnd <= {r_s6_rnd[14:0],
                               r_s6_rnd[15] ^ r_s6_rnd[14] ^ r_s6_rnd[12] ^ r_s6_rnd[3]};
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {7'd0, r_out_next_rnd, r_out_uphill, r_out_delta, r_out_accept};

endmodule
